// ===== sv/tpbl_pkg.sv =====
// shared types, constants and coefficient tables for the three-pole low-pass filter
package tpbl_pkg;

  // word and arithmetic widths
  localparam int SAMPLE_W      = 32;
  localparam int COEF_W        = 23;
  localparam int FRAC_SHIFT    = 20;
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int ACC_W         = PROD_W + 3;
  localparam int WIDE_W        = ACC_W - FRAC_SHIFT;
  localparam int PERIOD_W      = 5;
  localparam int WARM_W        = 4;
  localparam int ROM_SIZE      = 20;
  localparam int TABLE_ENTRIES = 20;
  localparam int IDX_W         = $clog2(ROM_SIZE);
  localparam int HIST_DEPTH    = 3;

  localparam logic [PERIOD_W-1:0] HP_RESET = PERIOD_W'(10);
  localparam logic [WARM_W-1:0]   WARM_MAX = WARM_W'(13);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef sample_t hist_t [HIST_DEPTH];
  typedef int micro_tab_t [ROM_SIZE];
  typedef coef_t coef_tab_t [ROM_SIZE];
  typedef logic [WARM_W-1:0] warm_tab_t [ROM_SIZE];

  // one selected coefficient set (b3 equals b0, b2 equals b1)
  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t a1;
    coef_t a2;
    coef_t a3;
  } coef_set_t;

  // coefficients in millionths
  localparam micro_tab_t B0_MICRO = '{170149, 100733, 50373, 27610, 16541, 10629, 7213, 5111,
    3750, 2831, 2188, 1726, 1385, 1128, 931, 778, 656, 558, 479, 414};
  localparam micro_tab_t B1_MICRO = '{510448, 302200, 151118, 82830, 49622, 31887, 21640,
    15334, 11250, 8492, 6565, 5179, 4156, 3385, 2794, 2333, 1967, 1674, 1437, 1242};
  localparam micro_tab_t A1_MICRO = '{-336246, 398405, 1080990, 1505892, 1783327, 1976163,
    2117205, 2224560, 2308883, 2376806, 2432658, 2479376, 2519020, 2553078, 2582648,
    2608560, 2631451, 2651819, 2670059, 2686486};
  localparam micro_tab_t A2_MICRO = '{-26816, -247486, -607116, -934652, -1200263, -1412114,
    -1582459, -1721388, -1836396, -1932941, -2015013, -2085571, -2146834, -2200500,
    -2247883, -2290012, -2327708, -2361631, -2392315, -2420202};
  localparam micro_tab_t A3_MICRO = '{1867, 43214, 123145, 207880, 284610, 350920, 407548,
    455938, 497514, 533488, 564848, 592385, 616731, 638395, 657784, 675232, 691011,
    705347, 718425, 730403};

  // warm-up length per period
  localparam warm_tab_t WARM_TAB = '{4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6,
    4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd13};

  // millionths to Q3.20, rounded half away from zero
  function automatic coef_tab_t q20_tab(input micro_tab_t micro);
    coef_tab_t res;
    longint    m;
    for (int i = 0; i < ROM_SIZE; i++) begin
      m = longint'(micro[i]);
      if (m >= 0) begin
        res[i] = COEF_W'((m * 1048576 + 500000) / 1000000);
      end else begin
        res[i] = COEF_W'(-(((-m) * 1048576 + 500000) / 1000000));
      end
    end
    return res;
  endfunction

  localparam coef_tab_t B0_TAB = q20_tab(B0_MICRO);
  localparam coef_tab_t B1_TAB = q20_tab(B1_MICRO);
  localparam coef_tab_t A1_TAB = q20_tab(A1_MICRO);
  localparam coef_tab_t A2_TAB = q20_tab(A2_MICRO);
  localparam coef_tab_t A3_TAB = q20_tab(A3_MICRO);

  // a period the register accepts
  function automatic logic period_ok(input logic [PERIOD_W-1:0] p);
    return (p != '0) && (p <= PERIOD_W'(TABLE_ENTRIES));
  endfunction

  // table row for a period
  function automatic logic [IDX_W-1:0] period_idx(input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] d;
    d = p - PERIOD_W'(1);
    return d[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/tpbl_sample_if.sv =====
// input channel carrying one sample word
interface tpbl_sample_if import tpbl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== sv/tpbl_filtered_if.sv =====
// result channel carrying one filtered word
interface tpbl_filtered_if import tpbl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

// ===== sv/three_pole_butterworth_lowpass.sv =====
// top level of the third-order butterworth low-pass filter
// Usage:
//   in_stream  : valid/ready channel, one signed Q16.16 sample word per transfer
//   out_stream : valid/ready channel, one saturated Q16.16 filtered word per transfer
//   cfg_we/cfg_data : half period write (1..20); other values are ignored.
//     A write reselects the coefficient set, clears the input and output
//     history and restarts the warm-up. Write only while the filter is idle.
// Timing:
//   a sample is held in an input register, the whole filter equation is
//   evaluated combinationally from it and the result lands in the output
//   register, from which the word is offered.
//   Throughput is one sample per cycle unless out_stream stalls, set by the
//   feedback path from the last output through the seven products to the history.
// Warm-up: after reset or a period write the first 1 to 13 samples (7 at the
//   reset period of 10) update the history but produce no word.
// Reset: rst_n is synchronous, active low; history cleared, period set to 10.
// Stall: while out_stream.ready is low a pending word holds, the input
//   register fills and then in_stream.ready drops; nothing is lost.
module three_pole_butterworth_lowpass import tpbl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  tpbl_sample_if.sink         in_stream,
  tpbl_filtered_if.source     out_stream,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data
);

  coef_set_t         coef;
  logic [WARM_W-1:0] warm_len;
  logic              restart;

  logic              s1_valid_r;
  sample_t           s1_sample_r;
  hist_t             g_r;
  hist_t             f_r;
  logic [WARM_W-1:0] warm_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  sample_t           out_filtered_r;
  sample_t           y;
  logic              advance;

  tpbl_coef_bank u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .coef     (coef),
    .warm_len (warm_len),
    .restart  (restart)
  );

  tpbl_mac u_mac (
    .coef (coef),
    .x    (s1_sample_r),
    .g    (g_r),
    .f    (f_r),
    .y    (y)
  );

  // handshake
  assign advance           = s1_valid_r && (!out_valid_r || out_stream.ready);
  assign in_stream.ready   = !s1_valid_r || advance;
  assign out_stream.valid  = out_valid_r;
  assign out_stream.filtered = out_filtered_r;

  // result register valid
  always_comb begin
    if (advance && (warm_r == '0)) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // input register and result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_stream.ready) begin
        s1_valid_r <= in_stream.valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      s1_sample_r <= in_stream.sample;
    end
    if (advance && (warm_r == '0)) begin
      out_filtered_r <= y;
    end
  end

  // filter history and warm-up counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        g_r[i] <= '0;
        f_r[i] <= '0;
      end
      warm_r <= WARM_TAB[period_idx(HP_RESET)];
    end else if (restart) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        g_r[i] <= '0;
        f_r[i] <= '0;
      end
      warm_r <= warm_len;
    end else if (advance) begin
      g_r[2] <= g_r[1];
      g_r[1] <= g_r[0];
      g_r[0] <= s1_sample_r;
      f_r[2] <= f_r[1];
      f_r[1] <= f_r[0];
      f_r[0] <= y;
      if (warm_r != '0) begin
        warm_r <= warm_r - WARM_W'(1);
      end
    end
  end

  // a warm-up sample never produces a word
  a_warm_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (warm_r != '0) && !restart |=> !out_valid_r)
    else $error("word produced during warm-up");

  // a sample after warm-up always produces a word
  a_warm_done: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (warm_r == '0) |=> out_valid_r && (out_filtered_r == $past(y)))
    else $error("word missing after warm-up");

  // warm-up count stays within the table range
  a_warm_range: assert property (@(posedge clk) disable iff (!rst_n)
    warm_r <= WARM_MAX)
    else $error("warm-up count out of range");

  // a period write restarts the filter
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (warm_r != '0) && (g_r[0] == '0) && (f_r[0] == '0))
    else $error("period write did not restart filter");

endmodule

// ===== sv/tpbl_coef_bank.sv =====
// coefficient set and warm-up length selected by the period register
module tpbl_coef_bank import tpbl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data,
  output coef_set_t           coef,
  output logic [WARM_W-1:0]   warm_len,
  output logic                restart
);

  coef_set_t        coef_r;
  logic [IDX_W-1:0] idx;

  // out-of-range periods are dropped
  assign restart  = cfg_we && period_ok(cfg_data);
  assign idx      = period_idx(cfg_data);
  assign warm_len = WARM_TAB[idx];
  assign coef     = coef_r;

  // load the selected row on reset and on each accepted write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= B0_TAB[period_idx(HP_RESET)];
      coef_r.b1 <= B1_TAB[period_idx(HP_RESET)];
      coef_r.a1 <= A1_TAB[period_idx(HP_RESET)];
      coef_r.a2 <= A2_TAB[period_idx(HP_RESET)];
      coef_r.a3 <= A3_TAB[period_idx(HP_RESET)];
    end else if (restart) begin
      coef_r.b0 <= B0_TAB[idx];
      coef_r.b1 <= B1_TAB[idx];
      coef_r.a1 <= A1_TAB[idx];
      coef_r.a2 <= A2_TAB[idx];
      coef_r.a3 <= A3_TAB[idx];
    end
  end

endmodule

// ===== sv/tpbl_mac.sv =====
// seven products, rounding and saturation for one filter output
module tpbl_mac import tpbl_pkg::*; (
  input  coef_set_t coef,
  input  sample_t   x,
  input  hist_t     g,
  input  hist_t     f,
  output sample_t   y
);

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_SHIFT - 1);

  logic signed [PROD_W-1:0] p_x, p_g0, p_g1, p_g2, p_f0, p_f1, p_f2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [WIDE_W-1:0] wide;
  logic [WIDE_W-SAMPLE_W:0] top_bits;

  // feed-forward and feedback products
  assign p_x  = coef.b0 * x;
  assign p_g0 = coef.b1 * g[0];
  assign p_g1 = coef.b1 * g[1];
  assign p_g2 = coef.b0 * g[2];
  assign p_f0 = coef.a1 * f[0];
  assign p_f1 = coef.a2 * f[1];
  assign p_f2 = coef.a3 * f[2];

  // sum with half an lsb, then drop the fraction (floor)
  assign acc = ACC_W'(p_x) + ACC_W'(p_g0) + ACC_W'(p_g1) + ACC_W'(p_g2)
             + ACC_W'(p_f0) + ACC_W'(p_f1) + ACC_W'(p_f2) + RND;
  assign wide     = acc[ACC_W-1:FRAC_SHIFT];
  assign top_bits = wide[WIDE_W-1:SAMPLE_W-1];

  // clamp to the word range
  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      y = wide[SAMPLE_W-1:0];
    end else if (wide[WIDE_W-1]) begin
      y = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule
